// File: design/tlbpt_pkg.sv
// Shared types and fixed widths for the TLB / page table translator.
// No dependencies; imported by every module of the block.
package tlbpt_pkg;

	localparam int ADDR_BITS  = 16;  // virtual and physical address width
	localparam int FRAME_BITS = 8;   // physical frame number width
	localparam int FREE_BITS  = 9;   // next-free-frame pointer width
	localparam int COUNT_BITS = 32;  // saturating hit and fault totals
	localparam int M_TDATA_BITS = 96;

	// Update command broadcast to every TLB cell
	typedef struct packed {
		logic commit;  // apply the update this cycle
		logic miss;    // request missed the TLB (insert a new entry)
	} tlbpt_ctl_t;

	// One page table entry
	typedef struct packed {
		logic                  valid;
		logic [FRAME_BITS-1:0] frame;
	} tlbpt_pte_t;

endpackage

// File: design/tlbpt_cell.sv
// One TLB slot of the recency-ordered chain (slot 0 is least recent).
// Depends on tlbpt_pkg. Neighbor data comes from the next more recent cell.
module tlbpt_cell #(
	parameter int PAGE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tlbpt_pkg::tlbpt_ctl_t           ctl,
	input  logic [PAGE_BITS-1:0]            look_page,
	input  logic [tlbpt_pkg::FRAME_BITS-1:0] new_frame,
	input  logic                            carry_in,
	input  logic                            prev_valid,
	input  logic                            next_valid,
	input  logic [PAGE_BITS-1:0]            next_page,
	input  logic [tlbpt_pkg::FRAME_BITS-1:0] next_frame,
	output logic                            valid,
	output logic [PAGE_BITS-1:0]            page,
	output logic [tlbpt_pkg::FRAME_BITS-1:0] frame,
	output logic                            match,
	output logic                            carry_out
);
	import tlbpt_pkg::*;

	logic                  valid_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  shift;
	logic                  take_next;
	logic                  load_new;

	// Tag compare; carry marks that this slot or a less recent one is removed
	// Empty slots above the fill level pass the carry on but never shift
	assign match     = valid_q && (page_q == look_page);
	assign carry_out = carry_in | match;
	assign shift     = carry_out && valid_q;

	// Removed slots pull from the more recent neighbor; the top of the run takes the request
	assign take_next = shift && next_valid;
	assign load_new  = (shift && !next_valid) || (!shift && ctl.miss && !valid_q && prev_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.commit && load_new) begin
			valid_q <= 1'b1;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (take_next) begin
				page_q  <= next_page;
				frame_q <= next_frame;
			end else if (load_new) begin
				page_q  <= look_page;
				frame_q <= new_frame;
			end
		end
	end

	assign valid = valid_q;
	assign page  = page_q;
	assign frame = frame_q;

endmodule

// File: design/tlbpt_page_table.sv
// Page table memory: one entry per page holding a valid bit and a frame.
// Depends on tlbpt_pkg. Cleared by a one-entry-per-cycle sweep after reset.
module tlbpt_page_table #(
	parameter int PAGE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [PAGE_BITS-1:0]            rd_addr,
	output tlbpt_pkg::tlbpt_pte_t           rd_data,
	input  logic                            wr_en,
	input  logic [PAGE_BITS-1:0]            wr_addr,
	input  logic [tlbpt_pkg::FRAME_BITS-1:0] wr_frame,
	output logic                            clearing
);
	import tlbpt_pkg::*;

	localparam int DEPTH = 1 << PAGE_BITS;

	tlbpt_pte_t           mem [DEPTH];
	tlbpt_pte_t           rd_q;
	logic                 clr_busy_q;
	logic [PAGE_BITS-1:0] clr_addr_q;

	// Clear sweep over every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {PAGE_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Single write port shared by sweep and updates
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= '{valid: 1'b1, frame: wr_frame};
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_q;
	assign clearing = clr_busy_q;

endmodule

// File: design/tlb_page_table_translator.sv
// Top level: LRU TLB (chain of tlbpt_cell) in front of a demand-paged page table.
// Depends on tlbpt_pkg, tlbpt_cell and tlbpt_page_table.
//
// channel   | direction | payload
// s_axis    | in        | tdata[15:0] virtual_address
// m_axis    | out       | tdata[89:0] physical_address, frame_number, tlb_hit,
//           |           |   page_fault, hit_total, fault_total (zero pad to 96)
//
// For each request the accept edge launches the page table read; the commit edge,
// which waits for a free output register, commits the TLB chain update, page
// table write and result. After reset the page table is swept clear, one entry
// per cycle, and s_axis_tready stays low for the whole sweep.
// The output register frees the pipeline while a result waits; a held result
// stalls only the commit of the following request.
module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = 16,
	parameter int PAGE_BITS   = 8,
	parameter int OFFSET_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] virtual_address
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] physical_address, [23:16] frame_number, [24] tlb_hit, [25] page_fault,
	// [57:26] hit_total, [89:58] fault_total, [95:90] zero
	output logic [95:0] m_axis_tdata
);
	import tlbpt_pkg::*;

	logic                   accept;
	logic                   commit;
	logic                   busy_q;
	logic                   clearing;
	logic [31:0]            va_ext;
	logic [PAGE_BITS-1:0]   page_in;
	logic [PAGE_BITS-1:0]   page_q;
	logic [OFFSET_BITS-1:0] offset_q;
	tlbpt_pte_t             pte;
	tlbpt_ctl_t             ctl;

	logic                   cell_valid [TLB_ENTRIES];
	logic [PAGE_BITS-1:0]   cell_page  [TLB_ENTRIES];
	logic [FRAME_BITS-1:0]  cell_frame [TLB_ENTRIES];
	logic                   cell_match [TLB_ENTRIES];
	logic                   carry      [TLB_ENTRIES+1];

	logic                   hit;
	logic                   fault;
	logic [FRAME_BITS-1:0]  hit_frame;
	logic [FRAME_BITS-1:0]  frame;
	logic [31:0]            pa_full;
	logic [FREE_BITS-1:0]   next_free_q;
	logic [COUNT_BITS-1:0]  hit_cnt_q;
	logic [COUNT_BITS-1:0]  fault_cnt_q;
	logic [COUNT_BITS-1:0]  hit_cnt_nxt;
	logic [COUNT_BITS-1:0]  fault_cnt_nxt;
	logic                   out_valid_q;
	logic [M_TDATA_BITS-1:0] out_data_q;

	// Handshake: one request in flight; commit waits for a free output register
	assign s_axis_tready = !busy_q && !clearing;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign commit        = busy_q && (!out_valid_q || m_axis_tready);

	// Address split; bits above page and offset are dropped
	assign va_ext  = {16'b0, s_axis_tdata};
	assign page_in = va_ext[OFFSET_BITS +: PAGE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q   <= page_in;
			offset_q <= s_axis_tdata[OFFSET_BITS-1:0];
		end
	end

	// Page table
	tlbpt_page_table #(
		.PAGE_BITS (PAGE_BITS)
	) u_page_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (page_in),
		.rd_data  (pte),
		.wr_en    (commit && fault),
		.wr_addr  (page_q),
		.wr_frame (frame),
		.clearing (clearing)
	);

	// TLB chain: a miss on a full chain shifts every slot, evicting slot 0
	assign carry[0]    = !hit && cell_valid[TLB_ENTRIES-1];
	assign ctl.commit  = commit;
	assign ctl.miss    = !hit;

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		logic                  prev_v;
		logic                  next_v;
		logic [PAGE_BITS-1:0]  next_p;
		logic [FRAME_BITS-1:0] next_f;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_prev
			assign prev_v = cell_valid[i-1];
		end

		if (i == TLB_ENTRIES-1) begin : g_last
			assign next_v = 1'b0;
			assign next_p = '0;
			assign next_f = '0;
		end else begin : g_next
			assign next_v = cell_valid[i+1];
			assign next_p = cell_page[i+1];
			assign next_f = cell_frame[i+1];
		end

		tlbpt_cell #(
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.look_page  (page_q),
			.new_frame  (frame),
			.carry_in   (carry[i]),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_page  (next_p),
			.next_frame (next_f),
			.valid      (cell_valid[i]),
			.page       (cell_page[i]),
			.frame      (cell_frame[i]),
			.match      (cell_match[i]),
			.carry_out  (carry[i+1])
		);
	end

	// Hit detect and frame select; at most one slot matches
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			hit       = hit | cell_match[i];
			hit_frame = hit_frame | (cell_match[i] ? cell_frame[i] : '0);
		end
	end

	// Frame resolution: TLB, then page table, else allocate
	assign fault = !hit && !pte.valid;
	always_comb begin
		priority if (hit) begin
			frame = hit_frame;
		end else if (pte.valid) begin
			frame = pte.frame;
		end else begin
			frame = next_free_q[FRAME_BITS-1:0];
		end
	end

	// Saturating totals
	assign hit_cnt_nxt   = (hit && hit_cnt_q != '1) ? hit_cnt_q + 1'b1 : hit_cnt_q;
	assign fault_cnt_nxt = (fault && fault_cnt_q != '1) ? fault_cnt_q + 1'b1 : fault_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else if (commit) begin
			if (fault) begin
				next_free_q <= next_free_q + 1'b1;
			end
			hit_cnt_q   <= hit_cnt_nxt;
			fault_cnt_q <= fault_cnt_nxt;
		end
	end

	// Result packing
	assign pa_full = (32'(frame) << OFFSET_BITS) | 32'(offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {6'b0, fault_cnt_nxt, hit_cnt_nxt, fault, hit, frame,
				pa_full[ADDR_BITS-1:0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
